@@ rtl/server_task_assigner_core_defines.svh @@
// Assertion macros shared by the block's checking code
`ifndef SERVER_TASK_ASSIGNER_CORE_DEFINES_SVH
`define SERVER_TASK_ASSIGNER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define STA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("server_task_assigner_core: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset
`define STA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("server_task_assigner_core: next-cycle check failed");

`endif

@@ rtl/sta_pkg.sv @@
package sta_pkg;

  // Field widths
  localparam int TIME_W = 48;
  localparam int SVC_W  = 32;
  localparam int ID_W   = 5;
  localparam int CFG_W  = 5;

  // Reset value of the server count register
  localparam logic [CFG_W-1:0] NUM_SERVERS_RST = CFG_W'(16);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;   // latch job, clear scan state
    logic issue;   // read one server entry, advance the scan counter
    logic sum;     // form the finish time and the chosen server
    logic commit;  // write back and load the result register
  } sta_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_issue;  // scan counter sits on the last active server
    logic out_free;    // result register can take a new result
  } sta_status_t;

endpackage

@@ rtl/sta_if.sv @@
// Job channel: one transaction per arriving job
interface sta_job_if;
  logic                       valid;
  logic                       ready;
  logic [sta_pkg::TIME_W-1:0] arrival_time;
  logic [sta_pkg::SVC_W-1:0]  service_time;

  modport source (output valid, arrival_time, service_time, input ready);
  modport sink   (input valid, arrival_time, service_time, output ready);
endinterface

// Result channel: one transaction per assigned job
interface sta_result_if;
  logic                       valid;
  logic                       ready;
  logic [sta_pkg::ID_W-1:0]   server_id;
  logic [sta_pkg::TIME_W-1:0] finish_time;

  modport source (output valid, server_id, finish_time, input ready);
  modport sink   (input valid, server_id, finish_time, output ready);
endinterface

@@ rtl/sta_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module sta_ram #(
  parameter  int WIDTH = 48,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sta_ctrl.sv @@
// Sequencer: accept a job, scan all active servers, sum, write back
module sta_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  sta_pkg::sta_status_t status,
  output sta_pkg::sta_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SUM,
    S_COMMIT
  } state_t;

  state_t state;

  // Commands decoded from the current state
  always_comb begin
    cmd        = '0;
    job_ready  = (state == S_IDLE);
    cmd.start  = (state == S_IDLE) && job_valid;
    cmd.issue  = (state == S_SCAN);
    cmd.sum    = (state == S_SUM);
    cmd.commit = (state == S_COMMIT) && status.out_free;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (status.last_issue) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/sta_datapath.sv @@
// Server table, scan logic, finish-time adder and result register
module sta_datapath #(
  parameter int MAX_SERVERS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sta_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [sta_pkg::TIME_W-1:0]  arrival_time,
  input  logic [sta_pkg::SVC_W-1:0]   service_time,
  input  sta_pkg::sta_cmd_t           cmd,
  output sta_pkg::sta_status_t        status,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [sta_pkg::ID_W-1:0]    server_id,
  output logic [sta_pkg::TIME_W-1:0]  finish_time
);

  localparam int TW   = sta_pkg::TIME_W;
  localparam int IDXW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW   = ((IDXW + 1) > sta_pkg::CFG_W) ? (IDXW + 1) : sta_pkg::CFG_W;
  localparam int SW   = ((IDXW > sta_pkg::ID_W) ? IDXW : sta_pkg::ID_W) + 1;

  // Configuration and per-server free flags
  logic [sta_pkg::CFG_W-1:0] num_servers;
  logic [MAX_SERVERS-1:0]    srv_free;

  // Job and scan state
  logic [TW-1:0]              arrival;
  logic [sta_pkg::SVC_W-1:0]  service;
  logic [IDXW-1:0]            cnt;
  logic                       eval_v;
  logic [IDXW-1:0]            eidx;
  logic                       found;
  logic [IDXW-1:0]            free_idx;
  logic                       min_v;
  logic [TW-1:0]              min_val;
  logic [IDXW-1:0]            min_idx;
  logic [TW-1:0]              finish;
  logic [IDXW-1:0]            pick;

  logic [TW-1:0]   rd_data;
  logic [CW-1:0]   num_w;
  logic [CW-1:0]   last_w;
  logic [IDXW-1:0] last_idx;
  logic            is_free;
  logic [TW-1:0]   base;
  logic [TW:0]     sum_w;
  logic [SW-1:0]   id_wide;

  // Last active index: a count of zero acts as one, above the table acts as full
  always_comb begin
    num_w = CW'(num_servers);
    if (num_w == '0) begin
      last_w = '0;
    end else if (num_w > CW'(MAX_SERVERS)) begin
      last_w = CW'(MAX_SERVERS - 1);
    end else begin
      last_w = num_w - CW'(1);
    end
    last_idx = last_w[IDXW-1:0];
  end

  assign status.last_issue = (cnt == last_idx);
  assign status.out_free   = !res_valid || res_ready;

  // busy_until table; a free entry's contents are never used
  sta_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_SERVERS)
  ) u_busy_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (pick),
    .wdata (finish),
    .raddr (cnt),
    .rdata (rd_data)
  );

  // Entry under evaluation is free if already free or its time has passed
  assign is_free = srv_free[eidx] || (rd_data <= arrival);

  // Saturating finish time
  assign base  = found ? arrival : min_val;
  assign sum_w = {1'b0, base} + (TW + 1)'(service);

  assign id_wide = SW'(pick) + SW'(1);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers <= sta_pkg::NUM_SERVERS_RST;
      srv_free    <= '1;
      eval_v      <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) num_servers <= cfg_wdata;
      eval_v <= cmd.issue;
      if (eval_v && is_free && !srv_free[eidx]) srv_free[eidx] <= 1'b1;
      if (cmd.commit) srv_free[pick] <= 1'b0;
      if (cmd.commit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Scan and result payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      arrival <= arrival_time;
      service <= service_time;
      cnt     <= '0;
      found   <= 1'b0;
      min_v   <= 1'b0;
    end
    if (cmd.issue) begin
      eidx <= cnt;
      cnt  <= cnt + IDXW'(1);
    end
    if (eval_v) begin
      if (is_free && !found) begin
        found    <= 1'b1;
        free_idx <= eidx;
      end
      // strict compare keeps the lowest id on ties
      if (!is_free && (!min_v || rd_data < min_val)) begin
        min_v   <= 1'b1;
        min_val <= rd_data;
        min_idx <= eidx;
      end
    end
    if (cmd.sum) begin
      finish <= sum_w[TW] ? '1 : sum_w[TW-1:0];
      pick   <= found ? free_idx : min_idx;
    end
    if (cmd.commit) begin
      server_id   <= id_wide[sta_pkg::ID_W-1:0];
      finish_time <= finish;
    end
  end

endmodule

@@ rtl/server_task_assigner_core.sv @@
// Flow: a job transaction starts SCAN, then DRAIN, SUM and COMMIT, which waits for
// a free result register; result valid is set as COMMIT completes. No new job is
// taken before that. SCAN reads the busy-until RAM per active server, one entry a
// cycle through its single read port. The result register lets the next job be
// taken while a result waits. Reset (rst, synchronous): all servers free, server count 16, no result held.
`include "server_task_assigner_core_defines.svh"

module server_task_assigner_core #(
  parameter int MAX_SERVERS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [sta_pkg::CFG_W-1:0] cfg_wdata,
  sta_job_if.sink                   job,
  sta_result_if.source              result
);

  sta_pkg::sta_cmd_t    cmd;
  sta_pkg::sta_status_t status;
  logic                 res_valid;

  // Sequencer
  sta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job.valid),
    .job_ready (job.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Server table and arithmetic
  sta_datapath #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .arrival_time (job.arrival_time),
    .service_time (job.service_time),
    .cmd          (cmd),
    .status       (status),
    .res_valid    (res_valid),
    .res_ready    (result.ready),
    .server_id    (result.server_id),
    .finish_time  (result.finish_time)
  );

  assign result.valid = res_valid;

  // A result is loaded only into a free or draining result register
  `STA_ASSERT_NOW(a_commit_slot, cmd.commit, !res_valid || result.ready)
  // A job transaction starts the scan; no second job is taken straight after
  `STA_ASSERT_NEXT(a_accept_busy, job.valid && job.ready, !job.ready && cmd.issue)
  // A new result appears only after a write-back
  `STA_ASSERT_NOW(a_result_origin, $rose(res_valid), $past(cmd.commit))

endmodule
